// ----- rtl/esd_pkg.sv -----
// Shared types and constants for the escape-stuffed deframer.
// Used by esd_decode, esd_outq and escape_stuffed_two_level_deframer_core.
`default_nettype none

package esd_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_FRAG_START = 2'd1,
    KIND_FORM_END   = 2'd2,
    KIND_FRAG_END   = 2'd3
  } kind_t;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_ESCAPE    = 2'd0;
  localparam logic [1:0] REG_FRAG_DLM  = 2'd1;
  localparam logic [1:0] REG_FORM_DLM  = 2'd2;

  localparam logic [7:0] ESCAPE_RST   = 8'd10;   // newline
  localparam logic [7:0] FRAG_DLM_RST = 8'd126;  // tilde
  localparam logic [7:0] FORM_DLM_RST = 8'd91;   // open bracket

  // Output queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0] escape_char;
    logic [7:0] fragment_delim;
    logic [7:0] form_delim;
  } cfg_t;

  typedef struct packed {
    logic escape_pending;
    logic in_fragment;
    logic form_just_closed;
  } dstate_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       completed;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/esd_decode.sv -----
// Per-byte destuffing decision: results (0..2) and next deframer state.
// Depends on esd_pkg.
`default_nettype none

module esd_decode (
  input  wire logic [7:0]       in_byte,
  input  wire esd_pkg::cfg_t    cfg,
  input  wire esd_pkg::dstate_t cur,
  output esd_pkg::dstate_t      nxt,
  output logic [1:0]            push_n,
  output esd_pkg::result_t      res0,
  output esd_pkg::result_t      res1
);
  import esd_pkg::*;

  logic is_esc, is_frag, is_form;

  assign is_esc  = (in_byte == cfg.escape_char);
  assign is_frag = (in_byte == cfg.fragment_delim);
  assign is_form = (in_byte == cfg.form_delim);

  always_comb begin
    nxt    = cur;
    push_n = 2'd0;
    res0   = '{kind: KIND_DATA, data: in_byte, completed: 1'b0, last: 1'b1};
    res1   = '{kind: KIND_DATA, data: in_byte, completed: 1'b0, last: 1'b1};

    if (cur.escape_pending) begin
      nxt.escape_pending = 1'b0;
      if (cur.in_fragment) begin
        nxt.form_just_closed = 1'b0;
        if (is_esc || is_frag || is_form) begin
          push_n = 2'd1;
        end else begin
          // escape not followed by a special byte: both go out as data
          push_n    = 2'd2;
          res0.data = cfg.escape_char;
          res0.last = 1'b0;
        end
      end
    end else if (is_esc) begin
      nxt.escape_pending = 1'b1;
    end else if (is_frag) begin
      push_n               = 2'd1;
      res0.data            = 8'd0;
      nxt.in_fragment      = ~cur.in_fragment;
      nxt.form_just_closed = 1'b0;
      if (cur.in_fragment) begin
        res0.kind      = KIND_FRAG_END;
        res0.completed = cur.form_just_closed;
      end else begin
        res0.kind = KIND_FRAG_START;
      end
    end else if (is_form) begin
      if (cur.in_fragment) begin
        push_n               = 2'd1;
        res0.kind            = KIND_FORM_END;
        res0.data            = 8'd0;
        nxt.form_just_closed = 1'b1;
      end
    end else if (cur.in_fragment) begin
      push_n               = 2'd1;
      nxt.form_just_closed = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/esd_outq.sv -----
// Small result queue: takes up to two results per cycle, hands out one.
// Depends on esd_pkg.
`default_nettype none

module esd_outq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [1:0]       push_n,
  input  wire esd_pkg::result_t res0,
  input  wire esd_pkg::result_t res1,
  output logic                  room2,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output esd_pkg::result_t      head
);
  import esd_pkg::*;

  result_t          q_r [QDEPTH];
  logic [QAW-1:0]   wp_r, wp_nxt;
  logic [QAW-1:0]   rp_r, rp_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign head      = q_r[rp_r];
  assign pop       = out_valid && out_ready;
  // two free slots needed before taking a byte
  assign room2     = (cnt_r <= (QAW+1)'(QDEPTH - 2));

  always_comb begin
    wp_nxt  = wp_r + QAW'(push_n);
    rp_nxt  = rp_r + QAW'(pop);
    cnt_nxt = cnt_r + (QAW+1)'(push_n) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wp_r] <= res0;
    end
    if (push_n == 2'd2) begin
      q_r[wp_r + QAW'(1)] <= res1;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH))
    else $error("result queue overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) |-> room2)
    else $error("push without room");

  a_push_code: assert property (@(posedge clk) disable iff (!rst_n)
    push_n != 2'd3)
    else $error("more than two results pushed");
`endif

endmodule

`default_nettype wire

// ----- rtl/escape_stuffed_two_level_deframer_core.sv -----
// Escape-stuffed deframer with fragment and form delimiters.
// Results are registered in the result queue and handed out in order behind those already queued.
// One byte per cycle while in_ready is high; a byte's two results are handed out in turn.
// in_ready drops only while the 4-entry result queue holds more than two results.
// Reset (rst_n low, synchronous): registers to defaults, deframer state cleared, queue empty.
// Depends on esd_pkg, esd_decode, esd_outq.
`default_nettype none

module escape_stuffed_two_level_deframer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input byte stream
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  // result stream
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_byte,
  output logic             out_last_form_completed,
  output logic             out_last_of_run,
  // APB-style register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import esd_pkg::*;

  cfg_t    cfg_r;
  dstate_t st_r, st_dec;
  dstate_t st_nxt;
  logic    in_fire;
  logic    room2;
  logic    cfg_wr;
  logic [1:0] dec_n, push_n;
  result_t res0, res1, head;

  // ---------------- register port ----------------
  // No wait states; write lands on the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.escape_char    <= ESCAPE_RST;
      cfg_r.fragment_delim <= FRAG_DLM_RST;
      cfg_r.form_delim     <= FORM_DLM_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ESCAPE:   cfg_r.escape_char    <= pwdata[7:0];
        REG_FRAG_DLM: cfg_r.fragment_delim <= pwdata[7:0];
        REG_FORM_DLM: cfg_r.form_delim     <= pwdata[7:0];
        default: ;  // unmapped slot, write dropped
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ESCAPE:   prdata = {24'd0, cfg_r.escape_char};
      REG_FRAG_DLM: prdata = {24'd0, cfg_r.fragment_delim};
      REG_FORM_DLM: prdata = {24'd0, cfg_r.form_delim};
      default:      prdata = 32'd0;
    endcase
  end

  // ---------------- byte decode ----------------
  // Decision is made on the incoming byte and the current state in one pass;
  // the results are written straight into the result queue.
  assign in_ready = room2;
  assign in_fire  = in_valid && in_ready;

  esd_decode u_decode (
    .in_byte (in_byte),
    .cfg     (cfg_r),
    .cur     (st_r),
    .nxt     (st_dec),
    .push_n  (dec_n),
    .res0    (res0),
    .res1    (res1)
  );

  assign st_nxt = in_fire ? st_dec : st_r;
  assign push_n = in_fire ? dec_n : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  // ---------------- result queue ----------------
  esd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .res0      (res0),
    .res1      (res1),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_kind                = head.kind;
  assign out_byte                = head.data;
  assign out_last_form_completed = head.completed;
  assign out_last_of_run         = head.last;

`ifndef SYNTHESIS
  // completed flag belongs to fragment end only
  a_completed_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind != KIND_FRAG_END)) |-> !out_last_form_completed)
    else $error("completed flag on non fragment-end result");

  // delimiter reports are always the only result of their byte
  a_delim_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_kind == KIND_FRAG_START) || (out_kind == KIND_FORM_END) ||
                   (out_kind == KIND_FRAG_END))) |-> out_last_of_run)
    else $error("delimiter report not last of run");

  // bare fragment delimiter flips fragment state
  a_frag_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !st_r.escape_pending && (in_byte == cfg_r.fragment_delim) &&
     (in_byte != cfg_r.escape_char)) |=> (st_r.in_fragment != $past(st_r.in_fragment)))
    else $error("fragment delimiter did not toggle state");

  // escape pending never survives a taken byte
  a_esc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && st_r.escape_pending) |=> !st_r.escape_pending)
    else $error("escape left pending");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/escape_stuffed_two_level_deframer_core_tb.sv -----
// Self-checking testbench for escape_stuffed_two_level_deframer_core.
// Predicts deframed results in-line and checks them against the result stream.
// Depends on esd_pkg and the deframer RTL; stimulus is seeded by the simulator.
`default_nettype none

module escape_stuffed_two_level_deframer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import esd_pkg::*;

  // Register slot with no register behind it; writes there must be dropped.
  localparam logic [1:0] REG_SPARE = 2'd3;

  // Generous bound: ~900 bytes, each worst case two results behind a long
  // output stall plus a long input gap, taken several times over.
  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_REPORTS = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic        out_last_form_completed;
  logic        out_last_of_run;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'h0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  escape_stuffed_two_level_deframer_core DUT (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_byte                 (in_byte),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_kind                (out_kind),
    .out_byte                (out_byte),
    .out_last_form_completed (out_last_form_completed),
    .out_last_of_run         (out_last_of_run),
    .psel                    (psel),
    .penable                 (penable),
    .pwrite                  (pwrite),
    .paddr                   (paddr),
    .pwdata                  (pwdata),
    .prdata                  (prdata),
    .pready                  (pready)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Deframer predictor: own copy of the delimiter registers and decode state.
  // ---------------------------------------------------------------------------
  logic [7:0] escape_byte = ESCAPE_RST;
  logic [7:0] frag_byte   = FRAG_DLM_RST;
  logic [7:0] form_byte   = FORM_DLM_RST;

  logic esc_pending = 1'b0;  // escape seen, next byte not yet read
  logic inside_frag = 1'b0;  // between fragment start and fragment end
  logic form_closed = 1'b0;  // last report inside this fragment was a form end

  result_t deframed_q [$];   // results still owed by the block, oldest first

  int  bytes_sent   = 0;
  int  mismatches   = 0;
  int  cycle_count  = 0;
  bit  in_gaps_on   = 1'b1;
  bit  out_stalls_on = 1'b1;

  function automatic result_t make_result(input kind_t k, input logic [7:0] d,
                                          input logic done);
    result_t r;
    r.kind      = k;
    r.data      = d;
    r.completed = done;
    r.last      = 1'b0;
    return r;
  endfunction

  // Works out the results one accepted raw byte causes and queues them.
  // Precedence on equal register values: escape, then fragment, then form.
  task automatic deframe_byte(input logic [7:0] b);
    result_t    res [2];
    logic [7:0] dat [2];
    int         nres;
    int         ndat;
    int         i;
    nres = 0;
    ndat = 0;
    if (esc_pending) begin
      esc_pending = 1'b0;
      if (b == escape_byte || b == frag_byte || b == form_byte) begin
        dat[0] = b;
        ndat   = 1;
      end else begin
        // escape followed by a plain byte: both come out as data
        dat[0] = escape_byte;
        dat[1] = b;
        ndat   = 2;
      end
    end else if (b == escape_byte) begin
      esc_pending = 1'b1;
    end else if (b == frag_byte) begin
      if (inside_frag) begin
        res[nres] = make_result(KIND_FRAG_END, 8'h00, form_closed);
      end else begin
        res[nres] = make_result(KIND_FRAG_START, 8'h00, 1'b0);
      end
      nres++;
      inside_frag = !inside_frag;
      form_closed = 1'b0;
    end else if (b == form_byte) begin
      // a form delimiter outside a fragment is dropped
      if (inside_frag) begin
        res[nres] = make_result(KIND_FORM_END, 8'h00, 1'b0);
        nres++;
        form_closed = 1'b1;
      end
    end else begin
      dat[0] = b;
      ndat   = 1;
    end
    // data outside a fragment is discarded, even when it came from an escape
    for (i = 0; i < ndat; i++) begin
      if (inside_frag) begin
        res[nres] = make_result(KIND_DATA, dat[i], 1'b0);
        nres++;
        form_closed = 1'b0;
      end
    end
    if (nres > 0) res[nres-1].last = 1'b1;
    for (i = 0; i < nres; i++) deframed_q.push_back(res[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every output transaction is matched against the oldest
  // queued prediction. Values are sampled at the edge, before any update.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (deframed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result kind=%0d byte=%02h done=%b last=%b",
                   $realtime, out_kind, out_byte, out_last_form_completed,
                   out_last_of_run);
      end else begin
        want = deframed_q.pop_front();
        if (out_kind !== want.kind || out_byte !== want.data ||
            out_last_form_completed !== want.completed ||
            out_last_of_run !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $write("%0t: result mismatch exp kind=%0d byte=%02h done=%b last=%b",
                   $realtime, want.kind, want.data, want.completed, want.last);
            $display(" got kind=%0d byte=%02h done=%b last=%b",
                     out_kind, out_byte, out_last_form_completed, out_last_of_run);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("escape_stuffed_two_level_deframer_core test failed");
      $finish;
    end
  end

  // Mostly short pauses, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Result-side backpressure: random stalls while enabled.
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (out_stalls_on && $urandom_range(0, 99) < 25) begin
      stall_left <= pick_gap();
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // One raw byte through the input handshake, then an optional idle gap.
  task automatic push_raw_byte(input logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    deframe_byte(b);
    bytes_sent++;
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and let every owed result drain; the few extra cycles cover
  // bytes still in flight that produce nothing.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup, then access until pready. Upper data bits are junk.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    logic [31:0] word;
    word       = $urandom();
    word[7:0]  = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ESCAPE:   escape_byte = val;
      REG_FRAG_DLM: frag_byte   = val;
      REG_FORM_DLM: form_byte   = val;
      default: ;
    endcase
  endtask

  task automatic set_delims(input logic [7:0] esc, input logic [7:0] frag,
                            input logic [7:0] form);
    write_reg(REG_ESCAPE, esc);
    write_reg(REG_FRAG_DLM, frag);
    write_reg(REG_FORM_DLM, form);
  endtask

  // Content byte of a well-formed frame, stuffed where it must be. Special
  // values are favored, and now and then a plain byte is escaped too.
  task automatic push_content_byte();
    logic [7:0] c;
    int         pick;
    if ($urandom_range(0, 99) < 30) begin
      pick = $urandom_range(0, 2);
      c = (pick == 0) ? escape_byte : (pick == 1) ? frag_byte : form_byte;
    end else begin
      c = 8'($urandom_range(0, 255));
    end
    if (c == escape_byte || c == frag_byte || c == form_byte ||
        $urandom_range(0, 9) == 0) begin
      push_raw_byte(escape_byte);
    end
    push_raw_byte(c);
  endtask

  // Fragment of up to four forms; the last form is closed only sometimes.
  task automatic push_fragment();
    int nforms;
    int len;
    int f;
    int k;
    push_raw_byte(frag_byte);
    nforms = $urandom_range(0, 4);
    for (f = 0; f < nforms; f++) begin
      len = $urandom_range(0, 6);
      for (k = 0; k < len; k++) push_content_byte();
      if (f < nforms - 1 || $urandom_range(0, 1) == 1) push_raw_byte(form_byte);
    end
    push_raw_byte(frag_byte);
  endtask

  // Mostly framed traffic, some line noise and broken sequences. Halfway
  // through, the sender holds off until the block has caught up.
  task automatic run_stream(input int count);
    int goal;
    int half;
    int r;
    int k;
    bit paused;
    goal   = bytes_sent + count;
    half   = bytes_sent + count / 2;
    paused = 1'b0;
    while (bytes_sent < goal) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        push_fragment();
      end else if (r < 85) begin
        for (k = $urandom_range(1, 4); k > 0; k--) push_raw_byte(8'($urandom_range(0, 255)));
      end else if (r < 93) begin
        // escaped fragment delimiter: no fragment toggle unless an escape is pending
        push_raw_byte(escape_byte);
        push_raw_byte(frag_byte);
      end else begin
        push_raw_byte(($urandom_range(0, 1) == 1) ? form_byte : escape_byte);
      end
      if (!paused && bytes_sent >= half) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every escape and delimiter case once, at reset register values.
  task automatic test_directed_defaults();
    logic [7:0] seq [25];
    seq = '{8'hFF, FORM_DLM_RST,                  // dropped outside a fragment
            ESCAPE_RST, FRAG_DLM_RST,              // escaped delimiter does not open
            FRAG_DLM_RST, 8'h00, 8'hFF,            // start, extreme data
            ESCAPE_RST, ESCAPE_RST,                // literal escape
            ESCAPE_RST, FRAG_DLM_RST,              // delimiter as data
            ESCAPE_RST, FORM_DLM_RST,
            ESCAPE_RST, 8'h41,                     // escape then plain: two results
            FORM_DLM_RST, FRAG_DLM_RST,            // end with closed form
            FRAG_DLM_RST, FORM_DLM_RST, 8'h33, FRAG_DLM_RST,  // end, form not closed
            FRAG_DLM_RST, ESCAPE_RST, FRAG_DLM_RST,           // stays open
            FRAG_DLM_RST};
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    foreach (seq[i]) push_raw_byte(seq[i]);
    wait_drained();
  endtask

  // A write to the spare slot must not disturb any delimiter.
  task automatic test_spare_register();
    write_reg(REG_SPARE, 8'h00);
    write_reg(REG_SPARE, FORM_DLM_RST);
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    push_raw_byte(FRAG_DLM_RST);
    push_raw_byte(8'h00);
    push_raw_byte(FORM_DLM_RST);
    push_raw_byte(ESCAPE_RST);
    push_raw_byte(8'h5A);
    push_raw_byte(FRAG_DLM_RST);
    wait_drained();
  endtask

  task automatic test_random_defaults();
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    run_stream(100);
    // back to back, no stalls
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    run_stream(60);
    wait_drained();
  endtask

  task automatic test_extreme_delims();
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    set_delims(8'h00, 8'hFF, 8'h80);
    run_stream(100);
    wait_drained();
    set_delims(8'hFF, 8'h00, 8'h7F);
    in_gaps_on = 1'b0;
    run_stream(100);
    wait_drained();
  endtask

  // Overlapping register values: escape wins over fragment, fragment over form.
  task automatic test_equal_delims();
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    set_delims(8'h55, 8'h55, 8'h55);
    run_stream(40);
    wait_drained();
    set_delims(8'h33, 8'h33, 8'h44);
    run_stream(40);
    wait_drained();
    set_delims(8'h10, 8'h20, 8'h20);
    run_stream(50);
    wait_drained();
    set_delims(8'h20, 8'h10, 8'h20);
    run_stream(50);
    wait_drained();
  endtask

  task automatic test_random_delims();
    int n;
    for (n = 0; n < 3; n++) begin
      in_gaps_on    = (n != 1);
      out_stalls_on = (n != 2);
      set_delims(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
      run_stream(80);
      wait_drained();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_defaults();
    test_spare_register();
    test_random_defaults();
    test_extreme_delims();
    test_equal_delims();
    test_random_delims();

    wait_drained();
    repeat (8) @(posedge clk);
    if (deframed_q.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", deframed_q.size());
    end
    if (mismatches == 0) begin
      $display("escape_stuffed_two_level_deframer_core test passed");
    end else begin
      $display("escape_stuffed_two_level_deframer_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
